>>> hdl/afr_pkg.sv
// Shared types and constants for the audio report framer.
package afr_pkg;

	localparam int SAMPLES_PER_REPORT = 64;
	localparam int REPORT_BYTES       = 141;

	localparam logic [31:0] CRC_POLY = 32'hEDB88320;
	localparam logic [31:0] CRC_SEED = ~32'hEADA2D49;

	localparam int SAMPLE_BASE = 13;

	localparam logic [1:0] CMD_SAMPLE  = 2'd0;
	localparam logic [1:0] CMD_FLUSH   = 2'd1;
	localparam logic [1:0] CMD_SILENCE = 2'd2;

	localparam logic [7:0] ID_RESET  = 8'h32;
	localparam logic [7:0] SEQ_RESET = 8'hFF;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] sample_byte;
	} afr_in_t;

	typedef struct packed {
		logic [63:0] report_word;
		logic [3:0]  byte_count;
		logic        last_word;
	} afr_out_t;

	typedef struct packed {
		logic       init;
		logic       step;
		logic [7:0] data;
	} afr_crc_ctl_t;

endpackage

>>> hdl/audio_report_framer_crc32_top.sv
// Audio report framer top: sample collection, report byte sequencer, word output.
//
//  channel | handshake              | payload
//  --------+------------------------+----------------------------------
//  src     | src_valid / src_ready  | src_beat  (cmd, sample_byte)
//  rpt     | rpt_valid / rpt_ready  | rpt_beat  (report_word, byte_count, last_word)
//  cfg     | cfg_we                 | cfg_wdata (header id byte)
//
// A beat that starts a report sets the byte sequencer running over REPORT_BYTES
// bytes, one byte per cycle unless stalled, the bytes before the CRC field going
// through the CRC byte unit; src_ready is low until the last word is loaded into
// the output register. A full word waiting on rpt_ready stalls the byte sequencer.
// No clearing pass after reset; the store is only read below the fill count.
module audio_report_framer_crc32_top #(
	parameter int SAMPLES_PER_REPORT = afr_pkg::SAMPLES_PER_REPORT,
	parameter int REPORT_BYTES       = afr_pkg::REPORT_BYTES
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              src_valid,
	output logic              src_ready,
	input  afr_pkg::afr_in_t  src_beat,
	output logic              rpt_valid,
	input  logic              rpt_ready,
	output afr_pkg::afr_out_t rpt_beat,
	input  logic              cfg_we,
	input  logic [7:0]        cfg_wdata
);

	localparam int AW       = $clog2(SAMPLES_PER_REPORT);
	localparam int FW       = $clog2(SAMPLES_PER_REPORT + 1);
	localparam int IW       = $clog2(REPORT_BYTES);
	localparam int CRC_SPAN = REPORT_BYTES - 4;
	localparam int SMP_END  = afr_pkg::SAMPLE_BASE + SAMPLES_PER_REPORT;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

	state_t            state_q;
	logic [7:0]        id_q;
	logic [7:0]        seq_q;
	logic [FW-1:0]     fill_q;
	logic [FW-1:0]     valid_q;
	logic              use_q;
	logic [IW-1:0]     idx_q;
	logic [2:0]        acnt_q;
	logic [63:0]       asm_q;
	afr_pkg::afr_out_t out_q;
	logic              out_valid_q;

	logic              accept;
	logic              start;
	logic [FW-1:0]     fill_inc;
	logic              last;
	logic              completes;
	logic              out_free;
	logic              step;
	logic [IW-1:0]     idx_next;
	logic [IW-1:0]     k;
	logic [7:0]        byte_val;
	logic [7:0]        rdata;
	logic [31:0]       crc;
	logic [31:0]       crc_fin;
	logic [1:0]        crc_sel;
	logic [63:0]       word_next;
	afr_pkg::afr_crc_ctl_t crc_ctl;

	assign src_ready = (state_q == ST_IDLE);
	assign accept    = src_valid && src_ready;
	assign fill_inc  = fill_q + FW'(1);

	always_comb begin
		start = 1'b0;
		if (accept) begin
			unique case (src_beat.cmd)
				afr_pkg::CMD_SAMPLE:  start = (fill_inc == FW'(SAMPLES_PER_REPORT));
				afr_pkg::CMD_FLUSH:   start = (fill_q != '0);
				afr_pkg::CMD_SILENCE: start = 1'b1;
				default:              start = 1'b0;
			endcase
		end
	end

	assign last      = (idx_q == IW'(REPORT_BYTES - 1));
	assign completes = last || (acnt_q == 3'd7);
	assign out_free  = !out_valid_q || rpt_ready;
	assign step      = (state_q == ST_RUN) && (!completes || out_free);
	assign idx_next  = step ? (last ? '0 : idx_q + IW'(1)) : idx_q;
	assign k         = idx_q - IW'(afr_pkg::SAMPLE_BASE);
	assign crc_fin   = ~crc;
	assign crc_sel   = 2'(idx_q - IW'(CRC_SPAN));

	always_comb begin
		byte_val = 8'd0;
		if (idx_q < IW'(afr_pkg::SAMPLE_BASE)) begin
			unique case (4'(idx_q))
				4'd0:    byte_val = id_q;
				4'd2:    byte_val = 8'h91;
				4'd3:    byte_val = 8'h07;
				4'd4:    byte_val = 8'hFE;
				4'd10:   byte_val = seq_q;
				4'd11:   byte_val = 8'h92;
				4'd12:   byte_val = 8'(SAMPLES_PER_REPORT);
				default: byte_val = 8'd0;
			endcase
		end else if (idx_q < IW'(SMP_END)) begin
			byte_val = (use_q && (k < IW'(valid_q))) ? rdata : 8'd0;
		end else if (idx_q >= IW'(CRC_SPAN)) begin
			byte_val = crc_fin[8*crc_sel +: 8];
		end
	end

	always_comb begin
		word_next = asm_q;
		word_next[8*acnt_q +: 8] = byte_val;
	end

	assign crc_ctl.init = start;
	assign crc_ctl.step = step && (idx_q < IW'(CRC_SPAN));
	assign crc_ctl.data = byte_val;

	afr_crc_unit u_crc (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (crc_ctl),
		.crc    (crc)
	);

	afr_sample_mem #(
		.DEPTH (SAMPLES_PER_REPORT),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (accept && (src_beat.cmd == afr_pkg::CMD_SAMPLE)),
		.waddr (AW'(fill_q)),
		.wdata (src_beat.sample_byte),
		.raddr (AW'(idx_next - IW'(afr_pkg::SAMPLE_BASE))),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			id_q <= afr_pkg::ID_RESET;
		end else if (cfg_we) begin
			id_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			seq_q   <= afr_pkg::SEQ_RESET;
			fill_q  <= '0;
			valid_q <= '0;
			use_q   <= 1'b0;
			idx_q   <= '0;
			acnt_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (src_beat.cmd)
							afr_pkg::CMD_SAMPLE: begin
								fill_q <= start ? '0 : fill_inc;
								if (start) begin
									seq_q   <= seq_q + 8'd1;
									valid_q <= fill_inc;
									use_q   <= 1'b1;
								end
							end
							afr_pkg::CMD_FLUSH: begin
								if (start) begin
									seq_q   <= seq_q + 8'd1;
									valid_q <= fill_q;
									use_q   <= 1'b1;
									fill_q  <= '0;
								end
							end
							afr_pkg::CMD_SILENCE: begin
								use_q <= 1'b0;
							end
							default: begin
							end
						endcase
					end
					if (start) begin
						state_q <= ST_RUN;
						idx_q   <= '0;
						acnt_q  <= '0;
					end
				end
				ST_RUN: begin
					if (step) begin
						idx_q  <= idx_next;
						acnt_q <= completes ? 3'd0 : acnt_q + 3'd1;
						if (last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			asm_q <= '0;
		end else if (step) begin
			asm_q <= completes ? 64'd0 : word_next;
		end
		if (step && completes) begin
			out_q.report_word <= word_next;
			out_q.byte_count  <= {1'b0, acnt_q} + 4'd1;
			out_q.last_word   <= last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && completes) begin
			out_valid_q <= 1'b1;
		end else if (rpt_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign rpt_valid = out_valid_q;
	assign rpt_beat  = out_q;

endmodule

>>> hdl/afr_crc_unit.sv
// Reflected CRC-32 register, one byte absorbed per step.
module afr_crc_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  afr_pkg::afr_crc_ctl_t ctl,
	output logic [31:0]          crc
);

	logic [31:0] crc_q;
	logic [31:0] crc_d;

	always_comb begin
		crc_d = crc_q ^ {24'd0, ctl.data};
		for (int b = 0; b < 8; b++) begin
			crc_d = (crc_d >> 1) ^ (crc_d[0] ? afr_pkg::CRC_POLY : 32'd0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= afr_pkg::CRC_SEED;
		end else if (ctl.init) begin
			crc_q <= afr_pkg::CRC_SEED;
		end else if (ctl.step) begin
			crc_q <= crc_d;
		end
	end

	assign crc = crc_q;

endmodule

>>> hdl/afr_sample_mem.sv
// Sample store: one write port, one registered read port.
module afr_sample_mem #(
	parameter int DEPTH = afr_pkg::SAMPLES_PER_REPORT,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem [DEPTH];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> hdl/afr_checker.sv
// Port-level checks for the audio report framer, bound to the top level.
module afr_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              src_ready,
	input logic              rpt_valid,
	input logic              rpt_ready,
	input afr_pkg::afr_out_t rpt_beat
);

	a_rpt_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rpt_valid && !rpt_ready) |=> (rpt_valid && $stable(rpt_beat)))
		else $error("report beat dropped or changed while stalled");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		rpt_valid |-> (rpt_beat.byte_count != 4'd0 && rpt_beat.byte_count <= 4'd8))
		else $error("byte count out of range");

	a_full_word: assert property (@(posedge clk) disable iff (!arst_n)
		(rpt_valid && !rpt_beat.last_word) |-> (rpt_beat.byte_count == 4'd8))
		else $error("short word before end of report");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(rpt_valid && !rpt_beat.last_word) |-> !src_ready)
		else $error("input taken while a report is under way");

endmodule

bind audio_report_framer_crc32_top afr_checker u_afr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.src_ready (src_ready),
	.rpt_valid (rpt_valid),
	.rpt_ready (rpt_ready),
	.rpt_beat  (rpt_beat)
);

>>> bench/audio_report_framer_crc32_top_tb.sv
// Self-checking testbench for the audio report framer: sample beats in, CRC-framed report words out.
`timescale 1ns / 1ps

module audio_report_framer_crc32_top_tb;
	import afr_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam logic [7:0] HDR_TAG    = 8'h91;
	localparam logic [7:0] HDR_LEN    = 8'h07;
	localparam logic [7:0] HDR_MARK   = 8'hFE;
	localparam logic [7:0] HDR_SUB    = 8'h92;
	localparam int WORDS_PER_REPORT   = (REPORT_BYTES + 7) / 8;
	localparam int CRC_SPAN           = REPORT_BYTES - 4;
	localparam int STALL_LIMIT        = 3000;
	localparam int SETTLE_CYCLES      = 16;
	localparam int ITEM_TARGET        = 430;

	class report_scoreboard;
		logic [7:0] hdr_id;
		logic [7:0] pcm_store [SAMPLES_PER_REPORT];
		int         fill;
		logic [7:0] seq_num;
		int         errors;
		afr_out_t   due_words [$];

		function new();
			hdr_id  = ID_RESET;
			fill    = 0;
			seq_num = SEQ_RESET;
			errors  = 0;
		endfunction

		task mismatch(input string what);
			$display("%0t ns mismatch: %s", $time, what);
			errors++;
		endtask

		function void build_report(input bit with_pcm);
			logic [7:0]  r [REPORT_BYTES];
			logic [31:0] crc;
			logic [63:0] word;
			afr_out_t    w;
			int          start;
			int          cnt;
			for (int i = 0; i < REPORT_BYTES; i++)
				r[i] = 8'h00;
			r[0]  = hdr_id;
			r[2]  = HDR_TAG;
			r[3]  = HDR_LEN;
			r[4]  = HDR_MARK;
			r[10] = seq_num;
			r[11] = HDR_SUB;
			r[12] = SAMPLES_PER_REPORT[7:0];
			if (with_pcm) begin
				for (int i = 0; i < fill && i < SAMPLES_PER_REPORT; i++)
					r[SAMPLE_BASE + i] = pcm_store[i];
			end
			crc = CRC_SEED;
			for (int i = 0; i < CRC_SPAN; i++) begin
				crc ^= {24'h0, r[i]};
				for (int k = 0; k < 8; k++)
					crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
			end
			crc = ~crc;
			for (int k = 0; k < 4; k++)
				r[CRC_SPAN + k] = crc[8 * k +: 8];
			for (int n = 0; n < WORDS_PER_REPORT; n++) begin
				start = n * 8;
				cnt   = (REPORT_BYTES - start > 8) ? 8 : REPORT_BYTES - start;
				word  = '0;
				for (int i = 0; i < cnt; i++)
					word[8 * i +: 8] = r[start + i];
				w.report_word = word;
				w.byte_count  = cnt[3:0];
				w.last_word   = (n == WORDS_PER_REPORT - 1);
				due_words.push_back(w);
			end
		endfunction

		function void take_beat(input afr_in_t b);
			case (b.cmd)
				CMD_SAMPLE: begin
					pcm_store[fill] = b.sample_byte;
					fill++;
					if (fill >= SAMPLES_PER_REPORT) begin
						seq_num++;
						build_report(1'b1);
						fill = 0;
					end
				end
				CMD_FLUSH: begin
					if (fill != 0) begin
						seq_num++;
						build_report(1'b1);
						fill = 0;
					end
				end
				CMD_SILENCE: build_report(1'b0);
				default: ;
			endcase
		endfunction

		task check_word(input afr_out_t got);
			afr_out_t want;
			if (due_words.size() == 0) begin
				mismatch($sformatf("unexpected word %h", got.report_word));
			end else begin
				want = due_words.pop_front();
				if (got.report_word !== want.report_word)
					mismatch($sformatf("report_word %h, want %h",
						got.report_word, want.report_word));
				if (got.byte_count !== want.byte_count)
					mismatch($sformatf("byte_count %0d, want %0d",
						got.byte_count, want.byte_count));
				if (got.last_word !== want.last_word)
					mismatch($sformatf("last_word %b, want %b",
						got.last_word, want.last_word));
			end
		endtask
	endclass

	logic     clk = 1'b0;
	logic     arst_n;
	logic     src_valid;
	logic     src_ready;
	afr_in_t  src_beat;
	logic     rpt_valid;
	logic     rpt_ready = 1'b0;
	afr_out_t rpt_beat;
	logic     cfg_we;
	logic [7:0] cfg_wdata;

	report_scoreboard sb;
	bit quiet = 1'b0;
	int fill_now = 0;
	int beat_total = 0;
	int stall_cycles = 0;

	audio_report_framer_crc32_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_ready (src_ready),
		.src_beat  (src_beat),
		.rpt_valid (rpt_valid),
		.rpt_ready (rpt_ready),
		.rpt_beat  (rpt_beat),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(negedge clk) begin
		rpt_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 6);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (src_valid && src_ready)
				sb.take_beat(src_beat);
			if (rpt_valid && rpt_ready)
				sb.check_word(rpt_beat);
			if ((src_valid && src_ready) || (rpt_valid && rpt_ready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	task automatic push_beat(input logic [1:0] op, input logic [7:0] data);
		afr_in_t b;
		b.cmd         = op;
		b.sample_byte = data;
		@(negedge clk);
		while (!quiet && $urandom_range(99) < 6) begin
			src_valid <= 1'b0;
			@(negedge clk);
		end
		src_valid <= 1'b1;
		src_beat  <= b;
		do @(posedge clk); while (!src_ready);
		if (op == CMD_SAMPLE)
			fill_now = (fill_now == SAMPLES_PER_REPORT - 1) ? 0 : fill_now + 1;
		else if (op == CMD_FLUSH)
			fill_now = 0;
		beat_total++;
	endtask

	task automatic send_pcm(input int n);
		for (int i = 0; i < n; i++)
			push_beat(CMD_SAMPLE, $urandom_range(255));
	endtask

	// drain all expected words, then let the sequencer settle before a register write or the final check
	task automatic wait_idle();
		@(negedge clk);
		src_valid <= 1'b0;
		while (sb.due_words.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_id(input logic [7:0] v);
		wait_idle();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we    <= 1'b0;
		sb.hdr_id = v;
	endtask

	task automatic random_step();
		int pick;
		pick = $urandom_range(99);
		if (pick < 50) begin
			send_pcm($urandom_range(1, 6));
			push_beat(CMD_FLUSH, $urandom_range(255));
		end else if (pick < 62) begin
			send_pcm(SAMPLES_PER_REPORT - fill_now);
		end else if (pick < 74) begin
			send_pcm($urandom_range(1, 8));
			push_beat(CMD_SILENCE, $urandom_range(255));
		end else if (pick < 82) begin
			push_beat(CMD_SILENCE, $urandom_range(255));
		end else if (pick < 92) begin
			push_beat(CMD_UNUSED, $urandom_range(255));
			push_beat(CMD_FLUSH, $urandom_range(255));
		end else begin
			send_pcm($urandom_range(1, 70));
		end
	endtask

	initial begin
		sb        = new();
		arst_n    = 1'b0;
		src_valid = 1'b0;
		src_beat  = '0;
		cfg_we    = 1'b0;
		cfg_wdata = 8'h00;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: empty and pending flush, unused command, silence with and without a pending chunk, id writes
		push_beat(CMD_FLUSH, 8'h00);
		push_beat(CMD_UNUSED, 8'hFF);
		push_beat(CMD_SILENCE, 8'hFF);
		push_beat(CMD_SAMPLE, 8'h00);
		push_beat(CMD_SAMPLE, 8'hFF);
		push_beat(CMD_SAMPLE, 8'h5A);
		push_beat(CMD_SILENCE, 8'h00);
		push_beat(CMD_FLUSH, 8'hFF);
		push_beat(CMD_FLUSH, 8'h00);
		push_beat(CMD_UNUSED, 8'h00);
		push_beat(CMD_SAMPLE, 8'hA5);
		push_beat(CMD_FLUSH, 8'h5A);
		write_id(8'h00);
		push_beat(CMD_SILENCE, 8'h00);
		write_id(8'hFF);
		push_beat(CMD_SILENCE, 8'hFF);
		send_pcm(SAMPLES_PER_REPORT - fill_now);

		for (int p = 0; p < 4; p++) begin
			case (p)
				0: write_id($urandom_range(255));
				1: write_id($urandom_range(255));
				2: write_id(8'h01);
				default: write_id(8'h80);
			endcase
			quiet = (p == 1);
			while (beat_total < ITEM_TARGET * (p + 1) / 4)
				random_step();
		end
		quiet = 1'b0;

		wait_idle();
		if (sb.errors == 0 && sb.due_words.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
